[hw/rtl/slxfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slxfp_pkg: shared definitions for the sync/length/xor frame parser
// Field widths, protocol constants, state encodings and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package slxfp_pkg;

  localparam int HOLD_DEPTH_DEF = 16;
  localparam int MAX_DATA_DEF   = 8;

  localparam int BYTE_W    = 8;
  localparam int TIMEOUT_W = 16;
  localparam int LEN_W     = 4;
  localparam int COUNT_W   = 3;

  // hold store layout: sync a, sync b, length, event, data..., check
  localparam int EVENT_ADDR  = 3;
  localparam int SYNC_B_ADDR = 1;
  localparam int LEN_ADDR    = 2;

  localparam logic [BYTE_W-1:0]    SYNC_A          = 8'h00;
  localparam logic [BYTE_W-1:0]    SYNC_B          = 8'hAA;
  localparam logic [BYTE_W-1:0]    BAD_EVENT_LO    = 8'h00;
  localparam logic [BYTE_W-1:0]    BAD_EVENT_HI    = 8'hFF;
  localparam logic [LEN_W-1:0]     LEN_MIN         = 4'd2;
  localparam logic [LEN_W-1:0]     LEN_MAX         = 4'd9;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_DEFAULT = 16'd300;

  localparam logic ACTION_BYTE = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_LENGTH = 3'd2,
    PH_EVENT  = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHECK  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    CTL_IDLE     = 3'd0,
    CTL_SCAN     = 3'd1,
    CTL_SCAN_LEN = 3'd2,
    CTL_FIX2     = 3'd3,
    CTL_EMIT     = 3'd4
  } ctl_state_t;

  typedef struct packed {
    logic in_ready;
    logic push;
    logic restart;
    logic hunt;
    logic load_len;
    logic load_event;
    logic inc_data;
    logic xor_init;
    logic xor_acc;
    logic scan_start;
    logic scan_step;
    logic fix_short;
    logic fix_len;
    logic fix_wr2;
    logic emit_start;
    logic emit_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic byte_acc;
    logic expire;
    logic is_sync_a;
    logic is_sync_b;
    logic len_ok;
    logic frame_min;
    logic data_full;
    logic data_last;
    logic hold_full;
    logic frame_good;
    logic pair_hit;
    logic at_end;
    logic rd_len_ok;
    logic out_free;
    logic emit_last;
  } ctl_status_t;

  function automatic logic len_ok(input logic [BYTE_W-1:0] v);
    return (v >= {4'd0, LEN_MIN}) && (v <= {4'd0, LEN_MAX});
  endfunction

endpackage

[hw/rtl/slxfp_item_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slxfp_item_if: input channel of the frame parser
// One transaction carries either a received byte or one timer tick.
// ----------------------------------------------------------------------------
interface slxfp_item_if;
  import slxfp_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);

endinterface

[hw/rtl/slxfp_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slxfp_result_if: output channel of the frame parser
// One transaction carries the event byte or one data byte of a good frame.
// ----------------------------------------------------------------------------
interface slxfp_result_if;
  import slxfp_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               is_event;
  logic [COUNT_W-1:0] payload_count;
  logic               last;

  modport source (output valid, output out_byte, output is_event,
                  output payload_count, output last, input ready);
  modport sink   (input valid, input out_byte, input is_event,
                  input payload_count, input last, output ready);

endinterface

[hw/rtl/slxfp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slxfp_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module slxfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/slxfp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slxfp_ctrl: frame parser controller
// Holds the parse phase and the sequencer that runs rescans and emission.
// ----------------------------------------------------------------------------
module slxfp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  slxfp_pkg::ctl_status_t status,
  output slxfp_pkg::ctl_cmd_t    cmd
);
  import slxfp_pkg::*;

  ctl_state_t state, state_next;
  phase_t     phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_IDLE;
      phase <= PH_HUNT;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      CTL_IDLE: begin
        if (status.byte_acc) begin
          unique case (phase)
            PH_SYNC2: begin
              priority if (status.is_sync_b && !status.hold_full) begin
                phase_next = PH_LENGTH;
              end else if (status.is_sync_a) begin
                phase_next = PH_SYNC2;
              end else begin
                phase_next = PH_HUNT;
              end
            end
            PH_LENGTH: begin
              if (!status.hold_full && status.len_ok) begin
                phase_next = PH_EVENT;
              end else begin
                phase_next = PH_HUNT;
              end
            end
            PH_EVENT: begin
              priority if (status.hold_full) begin
                phase_next = PH_HUNT;
              end else if (status.frame_min) begin
                phase_next = PH_CHECK;
              end else begin
                phase_next = PH_DATA;
              end
            end
            PH_DATA: begin
              priority if (status.data_full || status.hold_full) begin
                phase_next = PH_HUNT;
              end else if (status.data_last) begin
                phase_next = PH_CHECK;
              end
            end
            PH_CHECK: begin
              priority if (status.hold_full) begin
                phase_next = PH_HUNT;
              end else if (status.frame_good) begin
                phase_next = PH_HUNT;
                state_next = CTL_EMIT;
              end else begin
                state_next = CTL_SCAN;
              end
            end
            default: begin
              phase_next = status.is_sync_a ? PH_SYNC2 : PH_HUNT;
            end
          endcase
        end else if (status.expire && phase != PH_HUNT) begin
          phase_next = PH_HUNT;
        end
      end
      CTL_SCAN: begin
        priority if (status.pair_hit && status.at_end) begin
          phase_next = PH_LENGTH;
          state_next = CTL_IDLE;
        end else if (status.pair_hit) begin
          state_next = CTL_SCAN_LEN;
        end else if (status.at_end) begin
          phase_next = PH_HUNT;
          state_next = CTL_IDLE;
        end
      end
      CTL_SCAN_LEN: begin
        if (status.rd_len_ok) begin
          phase_next = PH_EVENT;
          state_next = CTL_FIX2;
        end else begin
          phase_next = PH_HUNT;
          state_next = CTL_IDLE;
        end
      end
      CTL_FIX2: begin
        state_next = CTL_IDLE;
      end
      CTL_EMIT: begin
        if (status.out_free && status.emit_last) begin
          state_next = CTL_IDLE;
        end
      end
      default: begin
        state_next = CTL_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state)
      CTL_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.byte_acc) begin
          unique case (phase)
            PH_SYNC2: begin
              priority if (status.is_sync_b && !status.hold_full) begin
                cmd.push     = 1'b1;
                cmd.xor_init = 1'b1;
              end else if (status.is_sync_a) begin
                cmd.restart = 1'b1;
              end else begin
                cmd.hunt = 1'b1;
              end
            end
            PH_LENGTH: begin
              if (!status.hold_full && status.len_ok) begin
                cmd.push     = 1'b1;
                cmd.xor_acc  = 1'b1;
                cmd.load_len = 1'b1;
              end else begin
                cmd.hunt = 1'b1;
              end
            end
            PH_EVENT: begin
              if (status.hold_full) begin
                cmd.hunt = 1'b1;
              end else begin
                cmd.push       = 1'b1;
                cmd.xor_acc    = 1'b1;
                cmd.load_event = 1'b1;
              end
            end
            PH_DATA: begin
              if (status.data_full || status.hold_full) begin
                cmd.hunt = 1'b1;
              end else begin
                cmd.push     = 1'b1;
                cmd.xor_acc  = 1'b1;
                cmd.inc_data = 1'b1;
              end
            end
            PH_CHECK: begin
              priority if (status.hold_full) begin
                cmd.hunt = 1'b1;
              end else if (status.frame_good) begin
                cmd.hunt       = 1'b1;
                cmd.emit_start = 1'b1;
              end else begin
                cmd.push       = 1'b1;
                cmd.scan_start = 1'b1;
              end
            end
            default: begin
              if (status.is_sync_a) begin
                cmd.restart = 1'b1;
              end else begin
                cmd.hunt = 1'b1;
              end
            end
          endcase
        end else if (status.expire && phase != PH_HUNT) begin
          cmd.hunt = 1'b1;
        end
      end
      CTL_SCAN: begin
        priority if (status.pair_hit && status.at_end) begin
          cmd.fix_short = 1'b1;
        end else if (status.pair_hit) begin
          // fetch the byte after the pair as the length candidate
          cmd.scan_step = 1'b1;
        end else if (status.at_end) begin
          cmd.hunt = 1'b1;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      CTL_SCAN_LEN: begin
        if (status.rd_len_ok) begin
          cmd.fix_len = 1'b1;
        end else begin
          cmd.hunt = 1'b1;
        end
      end
      CTL_FIX2: begin
        cmd.fix_wr2 = 1'b1;
      end
      CTL_EMIT: begin
        cmd.emit_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hw/rtl/slxfp_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slxfp_dp: frame parser datapath
// Hold store, counters, running xor, timeout and the result register.
// ----------------------------------------------------------------------------
module slxfp_dp #(
  parameter int HOLD_DEPTH = slxfp_pkg::HOLD_DEPTH_DEF,
  parameter int MAX_DATA   = slxfp_pkg::MAX_DATA_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [slxfp_pkg::TIMEOUT_W-1:0]  cfg_write_data,
  slxfp_item_if.sink                       item,
  slxfp_result_if.source                   result,
  input  slxfp_pkg::ctl_cmd_t              cmd,
  output slxfp_pkg::ctl_status_t           status
);
  import slxfp_pkg::*;

  localparam int AW = $clog2(HOLD_DEPTH);
  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam int DW = $clog2(MAX_DATA + 1);

  logic [TIMEOUT_W-1:0] timeout_reload;
  logic [TIMEOUT_W-1:0] timeout_left;
  logic [CW-1:0]        hold_count;
  logic [LEN_W-1:0]     frame_length;
  logic [DW-1:0]        data_count;
  logic [BYTE_W-1:0]    xor_sum;
  logic [BYTE_W-1:0]    event_byte;
  logic [AW-1:0]        cur_idx;
  logic                 prev_zero;
  logic [COUNT_W-1:0]   emit_k;
  logic                 out_valid;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_is_event;
  logic [COUNT_W-1:0]   out_count;
  logic                 out_last;

  logic                 accept;
  logic                 byte_acc;
  logic                 tick_acc;
  logic [BYTE_W-1:0]    rx;
  logic [LEN_W-1:0]     payload_len;
  logic [COUNT_W-1:0]   payload;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [BYTE_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [BYTE_W-1:0]    ram_rdata;

  assign item.ready = cmd.in_ready;
  assign accept     = item.valid && cmd.in_ready;
  assign byte_acc   = accept && (item.action == ACTION_BYTE);
  assign tick_acc   = accept && (item.action == ACTION_TICK);
  assign rx         = item.rx_byte;

  assign payload_len = frame_length - LEN_MIN;
  assign payload     = payload_len[COUNT_W-1:0];

  slxfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (HOLD_DEPTH)
  ) u_hold_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // write port: normal pushes, header restart, and re-seating after a rescan
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hold_count[AW-1:0];
    ram_wdata = rx;
    priority if (cmd.fix_wr2) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(LEN_ADDR);
      ram_wdata = ram_rdata;
    end else if (cmd.fix_short || cmd.fix_len) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(SYNC_B_ADDR);
      ram_wdata = SYNC_B;
    end else if (cmd.restart) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
    end else if (cmd.push) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cur_idx + AW'(1);
    priority if (cmd.scan_start) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(SYNC_B_ADDR);
    end else if (cmd.scan_step) begin
      ram_re = 1'b1;
    end else if (cmd.emit_start) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(EVENT_ADDR);
    end else if (cmd.emit_load && !status.emit_last) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(EVENT_ADDR) + AW'(emit_k) + AW'(1);
    end
  end

  always_comb begin
    status.byte_acc   = byte_acc;
    status.expire     = tick_acc && (timeout_left == TIMEOUT_W'(1));
    status.is_sync_a  = (rx == SYNC_A);
    status.is_sync_b  = (rx == SYNC_B);
    status.len_ok     = len_ok(rx);
    status.frame_min  = (frame_length == LEN_MIN);
    status.data_full  = (data_count >= DW'(MAX_DATA));
    status.data_last  = (int'(data_count) + 3) >= int'(frame_length);
    status.hold_full  = (hold_count >= CW'(HOLD_DEPTH));
    status.frame_good = (event_byte != BAD_EVENT_LO) && (event_byte != BAD_EVENT_HI)
                        && (xor_sum == rx);
    status.pair_hit   = prev_zero && (ram_rdata == SYNC_B);
    status.at_end     = (CW'(cur_idx) + CW'(1)) == hold_count;
    status.rd_len_ok  = len_ok(ram_rdata);
    status.out_free   = !out_valid || result.ready;
    status.emit_last  = (emit_k == payload);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_reload <= TIMEOUT_DEFAULT;
      timeout_left   <= '0;
      hold_count     <= '0;
      data_count     <= '0;
      frame_length   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        timeout_reload <= cfg_write_data;
      end

      if (byte_acc) begin
        timeout_left <= timeout_reload;
      end else if (tick_acc && timeout_left != '0) begin
        timeout_left <= timeout_left - TIMEOUT_W'(1);
      end

      priority if (cmd.hunt) begin
        hold_count <= '0;
      end else if (cmd.restart) begin
        hold_count <= CW'(1);
      end else if (cmd.fix_short) begin
        hold_count <= CW'(2);
      end else if (cmd.fix_len) begin
        hold_count <= CW'(3);
      end else if (cmd.push) begin
        hold_count <= hold_count + CW'(1);
      end

      priority if (cmd.hunt || cmd.restart || cmd.load_event || cmd.fix_len) begin
        data_count <= '0;
      end else if (cmd.inc_data) begin
        data_count <= data_count + DW'(1);
      end

      priority if (cmd.load_len) begin
        frame_length <= rx[LEN_W-1:0];
      end else if (cmd.fix_len) begin
        frame_length <= ram_rdata[LEN_W-1:0];
      end

      priority if (cmd.emit_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.xor_init || cmd.fix_short) begin
      xor_sum <= SYNC_B;
    end else if (cmd.fix_len) begin
      xor_sum <= SYNC_B ^ ram_rdata;
    end else if (cmd.xor_acc) begin
      xor_sum <= xor_sum ^ rx;
    end

    if (cmd.load_event) begin
      event_byte <= rx;
    end

    if (cmd.scan_start) begin
      cur_idx   <= AW'(SYNC_B_ADDR);
      prev_zero <= 1'b0;
    end else if (cmd.scan_step) begin
      cur_idx   <= cur_idx + AW'(1);
      prev_zero <= (ram_rdata == SYNC_A);
    end

    if (cmd.emit_start) begin
      emit_k <= '0;
    end else if (cmd.emit_load) begin
      emit_k <= emit_k + COUNT_W'(1);
    end

    if (cmd.emit_load) begin
      out_byte     <= ram_rdata;
      out_is_event <= (emit_k == '0);
      out_count    <= payload;
      out_last     <= status.emit_last;
    end
  end

  assign result.valid         = out_valid;
  assign result.out_byte      = out_byte;
  assign result.is_event      = out_is_event;
  assign result.payload_count = out_count;
  assign result.last          = out_last;

endmodule

[hw/rtl/sync_length_xor_frame_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser_unit: framed byte receiver
// Hunts for 0x00 0xAA, checks length, event and xor, emits good frames.
// ----------------------------------------------------------------------------
// Each input transaction is a received byte or a timer tick. A tick, or a
// byte that does not close a frame, is taken while the controller is idle,
// and the next transaction can be taken in the following cycle. The check
// byte of a good frame starts emission: one result per cycle from the hold
// ram read port while the sink keeps ready high. A rejected frame is
// rescanned through the same read port at one held byte per cycle, and a
// header found in it is re-seated in CTL_SCAN, CTL_SCAN_LEN and CTL_FIX2.
// The output register lets the next byte be taken while the last result
// waits. The timeout reload register resets to 300 ticks; zero disables the
// timeout.
module sync_length_xor_frame_parser_unit #(
  parameter int HOLD_DEPTH = slxfp_pkg::HOLD_DEPTH_DEF,
  parameter int MAX_DATA   = slxfp_pkg::MAX_DATA_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [slxfp_pkg::TIMEOUT_W-1:0] cfg_write_data,
  slxfp_item_if.sink                      item,
  slxfp_result_if.source                  result
);
  import slxfp_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  slxfp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  slxfp_dp #(
    .HOLD_DEPTH (HOLD_DEPTH),
    .MAX_DATA   (MAX_DATA)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item           (item),
    .result         (result),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

[tb/sync_length_xor_frame_parser_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser_unit_tb: self-checking bench for the parser
// Feeds received bytes and timer ticks, predicts the event and data bytes of
// each good frame and compares every result transaction in order. Runs one
// directed sequence, then random well-formed, broken and noisy frames over
// several timeout settings with random idling on both channels.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_parser_unit_tb;
  import slxfp_pkg::*;

  localparam int CLK_HALF         = 10;
  localparam int RESET_CYCLES     = 5;
  localparam int SETTLE_CYCLES    = 32;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int BYTES_PER_PHASE  = 70;
  // watchdog: the run fails once the cycle count passes this limit
  localparam int CYCLE_LIMIT      = 1000000;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               is_event;
    logic [COUNT_W-1:0] payload_count;
    logic               last;
  } frame_beat_t;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] rx_byte;
  } rx_item_t;

  class frame_run_scoreboard;
    phase_t             phase;
    logic [BYTE_W-1:0]  held [HOLD_DEPTH_DEF];
    int                 held_cnt;
    logic [LEN_W-1:0]   frame_len;
    int                 data_cnt;
    logic [TIMEOUT_W-1:0] timeout_left;
    logic [TIMEOUT_W-1:0] reload_value;
    frame_beat_t        expected_beats [$];
    int                 error_count;

    function new();
      phase        = PH_HUNT;
      held_cnt     = 0;
      data_cnt     = 0;
      frame_len    = '0;
      timeout_left = '0;
      reload_value = TIMEOUT_DEFAULT;
      error_count  = 0;
    endfunction

    function void restart_hunt();
      phase    = PH_HUNT;
      held_cnt = 0;
      data_cnt = 0;
    endfunction

    function bit push_held(logic [BYTE_W-1:0] b);
      if (held_cnt >= HOLD_DEPTH_DEF) begin
        restart_hunt();
        return 1'b0;
      end
      held[held_cnt] = b;
      held_cnt++;
      return 1'b1;
    endfunction

    function bit length_in_range(logic [BYTE_W-1:0] v);
      return (v >= LEN_MIN) && (v <= LEN_MAX);
    endfunction

    function bit frame_is_good();
      logic [BYTE_W-1:0] x;
      int i;
      if (held_cnt < 4) return 1'b0;
      if (held[0] != SYNC_A || held[1] != SYNC_B) return 1'b0;
      if (!length_in_range(held[2]) || held_cnt != 3 + held[2]) return 1'b0;
      if (held[3] == BAD_EVENT_LO || held[3] == BAD_EVENT_HI) return 1'b0;
      x = '0;
      for (i = 1; i <= held[2] + 1; i++) x ^= held[i];
      return x == held[held_cnt - 1];
    endfunction

    // look for a later header inside a rejected frame
    function void rescan_held();
      int i;
      int j;
      int rem;
      for (i = 1; i + 1 < held_cnt; i++) begin
        if (held[i] == SYNC_A && held[i + 1] == SYNC_B) begin
          rem = held_cnt - i;
          for (j = 0; j < rem; j++) held[j] = held[i + j];
          held_cnt = rem;
          if (rem == 2) begin
            phase = PH_LENGTH;
            return;
          end
          if (length_in_range(held[2])) begin
            frame_len = held[2][LEN_W-1:0];
            held_cnt  = 3;
            data_cnt  = 0;
            phase     = PH_EVENT;
            return;
          end
          break;
        end
      end
      restart_hunt();
    endfunction

    function void note_rx_item(logic action, logic [BYTE_W-1:0] b);
      frame_beat_t beat;
      int k;
      int nd;
      if (action == ACTION_TICK) begin
        if (timeout_left != 0) begin
          timeout_left = timeout_left - 1'b1;
          if (timeout_left == 0 && phase != PH_HUNT) restart_hunt();
        end
        return;
      end
      timeout_left = reload_value;
      case (phase)
        PH_SYNC2: begin
          if (b == SYNC_B) begin
            if (push_held(b)) phase = PH_LENGTH;
          end else if (b == SYNC_A) begin
            held[0]  = b;
            held_cnt = 1;
          end else begin
            restart_hunt();
          end
        end
        PH_LENGTH: begin
          if (push_held(b)) begin
            if (length_in_range(b)) begin
              frame_len = b[LEN_W-1:0];
              phase     = PH_EVENT;
            end else begin
              restart_hunt();
            end
          end
        end
        PH_EVENT: begin
          if (push_held(b)) begin
            data_cnt = 0;
            phase    = (frame_len == LEN_MIN) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          if (data_cnt >= MAX_DATA_DEF) begin
            restart_hunt();
          end else if (push_held(b)) begin
            data_cnt++;
            if (data_cnt + 2 >= frame_len) phase = PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (push_held(b)) begin
            if (frame_is_good()) begin
              nd = frame_len - 2;
              for (k = 0; k <= nd; k++) begin
                beat.out_byte      = held[3 + k];
                beat.is_event      = (k == 0);
                beat.payload_count = nd[COUNT_W-1:0];
                beat.last          = (k == nd);
                expected_beats.push_back(beat);
              end
              restart_hunt();
            end else begin
              rescan_held();
            end
          end
        end
        default: begin
          if (phase == PH_HUNT && b == SYNC_A) begin
            held[0]  = b;
            held_cnt = 1;
            data_cnt = 0;
            phase    = PH_SYNC2;
          end else begin
            restart_hunt();
          end
        end
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        error_count++;
      end
    endfunction

    function void check_beat(frame_beat_t got);
      frame_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("unexpected result: out_byte 0x%0h is_event %0d payload_count %0d last %0d",
               got.out_byte, got.is_event, got.payload_count, got.last);
        error_count++;
        return;
      end
      want = expected_beats.pop_front();
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("is_event", want.is_event, got.is_event);
      compare_field("payload_count", want.payload_count, got.payload_count);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write_en;
  logic [TIMEOUT_W-1:0] cfg_write_data;

  slxfp_item_if   item_ch ();
  slxfp_result_if result_ch ();

  sync_length_xor_frame_parser_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item           (item_ch),
    .result         (result_ch)
  );

  frame_run_scoreboard frame_board = new();
  rx_item_t            rx_items [$];
  logic [BYTE_W-1:0]   frame_data [MAX_DATA_DEF];
  int                  phase_bytes;
  int                  src_stretch_left;
  bit                  tick_noise;
  bit                  hold_off_request;
  int                  cycle_count;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (result_ch.valid && result_ch.ready)
      frame_board.check_beat({result_ch.out_byte, result_ch.is_event,
                              result_ch.payload_count, result_ch.last});
  end

  // idle cycles before the next transaction, with occasional no-idle stretches
  function automatic int draw_idle(inout int stretch_left);
    if (stretch_left > 0) begin
      stretch_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) stretch_left = $urandom_range(8, 40);
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [BYTE_W-1:0] random_data_byte();
    case ($urandom_range(0, 7))
      0:       return SYNC_A;
      1:       return SYNC_B;
      2:       return BAD_EVENT_HI;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] random_bad_length();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(0, LEN_MIN - 1));
      1:       return 8'($urandom_range(LEN_MAX + 1, 15));
      default: return 8'($urandom_range(16, 255));
    endcase
  endfunction

  function automatic void fill_frame_data();
    int i;
    for (i = 0; i < MAX_DATA_DEF; i++) frame_data[i] = random_data_byte();
  endfunction

  function automatic void add_byte(logic [BYTE_W-1:0] b);
    rx_items.push_back('{ACTION_BYTE, b});
  endfunction

  function automatic void add_ticks(int n);
    int i;
    for (i = 0; i < n; i++) rx_items.push_back('{ACTION_TICK, 8'($urandom_range(0, 255))});
  endfunction

  // short runs, or runs that land just before or exactly on expiry
  function automatic int tick_run_length();
    int reload;
    reload = frame_board.reload_value;
    case ($urandom_range(0, 3))
      0: if (reload != 0 && reload <= TIMEOUT_DEFAULT) return reload;
      1: if (reload > 1 && reload <= TIMEOUT_DEFAULT) return reload - 1;
      default: ;
    endcase
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [BYTE_W-1:0] frame_xor(logic [BYTE_W-1:0] len,
                                                  logic [BYTE_W-1:0] ev);
    logic [BYTE_W-1:0] x;
    int i;
    x = SYNC_B ^ len ^ ev;
    for (i = 0; i < len - 2; i++) x ^= frame_data[i];
    return x;
  endfunction

  function automatic void add_header(logic [BYTE_W-1:0] len);
    add_byte(SYNC_A);
    add_byte(SYNC_B);
    add_byte(len);
  endfunction

  // event, data and check byte; check_flip nonzero corrupts the check
  function automatic void add_body(logic [BYTE_W-1:0] len, logic [BYTE_W-1:0] ev,
                                   logic [BYTE_W-1:0] check_flip);
    int i;
    for (i = 0; i <= len - 1; i++) begin
      if (tick_noise && $urandom_range(0, 11) == 0) add_ticks(tick_run_length());
      if (i == 0)
        add_byte(ev);
      else if (i == len - 1)
        add_byte(frame_xor(len, ev) ^ check_flip);
      else
        add_byte(frame_data[i - 1]);
    end
  endfunction

  function automatic void add_random_sequence();
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] len2;
    logic [BYTE_W-1:0] ev;
    int pick;
    int nd;
    int pos;
    int i;
    pick = $urandom_range(0, 99);
    len  = 8'($urandom_range(LEN_MIN, LEN_MAX));
    ev   = 8'($urandom_range(1, 254));
    fill_frame_data();
    if (pick < 60) begin
      add_header(len);
      add_body(len, ev, '0);
    end else if (pick < 68) begin
      add_header(len);
      add_body(len, ev, 8'($urandom_range(1, 255)));
    end else if (pick < 73) begin
      add_header(len);
      add_body(len, $urandom_range(0, 1) ? BAD_EVENT_HI : BAD_EVENT_LO, '0);
    end else if (pick < 79) begin
      add_header(random_bad_length());
    end else if (pick < 84) begin
      add_byte(SYNC_A);
      add_byte($urandom_range(0, 1) ? SYNC_A : 8'($urandom_range(1, 255)));
    end else if (pick < 92) begin
      len  = 8'($urandom_range(5, LEN_MAX));
      nd   = len - 2;
      len2 = 8'($urandom_range(LEN_MIN, LEN_MAX));
      if ($urandom_range(0, 1)) begin
        // header pair closes the rejected frame, so its length follows
        frame_data[nd - 1] = SYNC_A;
        add_header(len);
        add_body(len, BAD_EVENT_HI, frame_xor(len, BAD_EVENT_HI) ^ SYNC_B);
        add_byte(len2);
      end else begin
        pos = $urandom_range(0, nd - 3);
        if ($urandom_range(0, 3) == 0) len2 = random_bad_length();
        frame_data[pos]     = SYNC_A;
        frame_data[pos + 1] = SYNC_B;
        frame_data[pos + 2] = len2;
        add_header(len);
        add_body(len, ev, 8'($urandom_range(1, 255)));
      end
      fill_frame_data();
      add_body(len2, 8'($urandom_range(1, 254)), '0);
    end else if (pick < 96) begin
      nd = $urandom_range(1, 6);
      for (i = 0; i < nd; i++) add_byte(random_data_byte());
    end else begin
      add_ticks(tick_run_length());
    end
  endfunction

  task automatic drive_queued();
    rx_item_t it;
    int gap;
    while (rx_items.size() != 0) begin
      it  = rx_items.pop_front();
      gap = draw_idle(src_stretch_left);
      if (gap != 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      item_ch.valid   <= 1'b1;
      item_ch.action  <= it.action;
      item_ch.rx_byte <= it.rx_byte;
      do @(posedge clk); while (!item_ch.ready);
      frame_board.note_rx_item(it.action, it.rx_byte);
      if (it.action == ACTION_BYTE) phase_bytes++;
    end
  endtask

  // drop valid, drain all pending results, then give a rescan time to finish
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (frame_board.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random();
    phase_bytes = 0;
    while (phase_bytes < BYTES_PER_PHASE) begin
      add_random_sequence();
      drive_queued();
    end
    settle();
  endtask

  task automatic run_phase(input logic [TIMEOUT_W-1:0] reload, input bit long_hold);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= reload;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    frame_board.reload_value = reload;
    if (long_hold) begin
      // sink stalls while the source keeps offering back to back
      hold_off_request = 1'b1;
      src_stretch_left = 200;
    end
    run_random();
  endtask

  initial begin
    int gap;
    int stretch_left;
    stretch_left = 0;
    result_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      gap = draw_idle(stretch_left);
      if (gap != 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
    end
  end

  initial begin
    cycle_count      = 0;
    src_stretch_left = 0;
    tick_noise       = 1'b0;
    hold_off_request = 1'b0;
    rst              <= 1'b1;
    cfg_write_en     <= 1'b0;
    cfg_write_data   <= '0;
    item_ch.valid    <= 1'b0;
    item_ch.action   <= ACTION_BYTE;
    item_ch.rx_byte  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // second sync byte repeats the first, shortest good frame
    add_byte(SYNC_A);
    add_header(LEN_MIN);
    add_body(LEN_MIN, 8'h01, '0);
    // second sync wrong, then length above range
    add_byte(SYNC_A);
    add_byte(8'h55);
    add_header(8'h0A);
    // longest frame with a bad event; a header inside it resumes a short frame
    frame_data = '{SYNC_A, SYNC_B, 8'h03, 8'hFE, 8'h80, 8'h7F, 8'h01, 8'h00};
    add_header(LEN_MAX);
    add_body(LEN_MAX, BAD_EVENT_HI, '0);
    frame_data[0] = 8'h80;
    add_body(8'h03, 8'hFE, '0);
    add_ticks(1);
    drive_queued();

    tick_noise = 1'b1;
    run_random();
    run_phase(16'd1, 1'b0);
    run_phase(16'd0, 1'b1);
    run_phase(16'hFFFF, 1'b0);
    run_phase(16'd2, 1'b0);
    run_phase(TIMEOUT_DEFAULT, 1'b0);

    if (frame_board.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
